@@ design/rtdlut_pkg.sv @@
// ----------------------------------------------------------------------------
// rtdlut_pkg
// Shared types, constants and the Pt100 resistance ROM for the RTD converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rtdlut_pkg;

  localparam int TABLE_LAST_INDEX    = 1050;
  localparam int TEMP_AT_FIRST_ENTRY = -200;
  localparam int ROM_COUNT           = 1051;

  localparam int LAST_IDX = (TABLE_LAST_INDEX < ROM_COUNT - 1) ?
                            TABLE_LAST_INDEX : ROM_COUNT - 1;
  localparam int IDX_W    = $clog2(ROM_COUNT);

  localparam int RES_W  = 16;
  localparam int TEMP_W = 18;
  localparam int FRAC_W = 7;
  localparam int NUM_W  = 23;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam logic [6:0] CENTI = 7'd100;

  localparam logic [TEMP_W-1:0] TEMP_LOW_C  = TEMP_W'(TEMP_AT_FIRST_ENTRY * 100);
  localparam logic [TEMP_W-1:0] TEMP_HIGH_C =
    TEMP_W'((TEMP_AT_FIRST_ENTRY + LAST_IDX) * 100);

  typedef enum logic [1:0] {
    CLS_BELOW,
    CLS_ABOVE,
    CLS_MID
  } cls_t;

  typedef struct packed {
    logic [RES_W-1:0] scaled;
    cls_t             cls;
  } item_t;

  localparam logic [15:0] ROM_TABLE [ROM_COUNT] = '{
    16'd1852, 16'd1896, 16'd1939, 16'd1982, 16'd2025, 16'd2068, 16'd2111, 16'd2154, 16'd2197, 16'd2240,
    16'd2283, 16'd2326, 16'd2369, 16'd2412, 16'd2455, 16'd2497, 16'd2539, 16'd2582, 16'd2625, 16'd2667,
    16'd2710, 16'd2752, 16'd2795, 16'd2837, 16'd2880, 16'd2922, 16'd2965, 16'd3007, 16'd3049, 16'd3092,
    16'd3134, 16'd3176, 16'd3218, 16'd3261, 16'd3303, 16'd3345, 16'd3386, 16'd3428, 16'd3470, 16'd3512,
    16'd3554, 16'd3596, 16'd3638, 16'd3680, 16'd3722, 16'd3763, 16'd3805, 16'd3847, 16'd3889, 16'd3931,
    16'd3972, 16'd4014, 16'd4056, 16'd4097, 16'd4139, 16'd4180, 16'd4222, 16'd4264, 16'd4305, 16'd4346,
    16'd4388, 16'd4429, 16'd4471, 16'd4512, 16'd4553, 16'd4595, 16'd4635, 16'd4676, 16'd4718, 16'd4759,
    16'd4800, 16'd4841, 16'd4882, 16'd4923, 16'd4964, 16'd5006, 16'd5047, 16'd5088, 16'd5129, 16'd5170,
    16'd5211, 16'd5252, 16'd5292, 16'd5333, 16'd5374, 16'd5415, 16'd5456, 16'd5497, 16'd5538, 16'd5578,
    16'd5619, 16'd5660, 16'd5700, 16'd5741, 16'd5782, 16'd5822, 16'd5863, 16'd5904, 16'd5944, 16'd5985,
    16'd6026, 16'd6067, 16'd6107, 16'd6148, 16'd6187, 16'd6229, 16'd6269, 16'd6310, 16'd6350, 16'd6391,
    16'd6430, 16'd6470, 16'd6511, 16'd6551, 16'd6591, 16'd6631, 16'd6672, 16'd6712, 16'd6752, 16'd6792,
    16'd6833, 16'd6873, 16'd6913, 16'd6953, 16'd6993, 16'd7033, 16'd7073, 16'd7113, 16'd7153, 16'd7193,
    16'd7233, 16'd7273, 16'd7313, 16'd7353, 16'd7393, 16'd7433, 16'd7473, 16'd7513, 16'd7553, 16'd7593,
    16'd7633, 16'd7673, 16'd7713, 16'd7752, 16'd7792, 16'd7832, 16'd7872, 16'd7911, 16'd7951, 16'd7991,
    16'd8031, 16'd8070, 16'd8110, 16'd8150, 16'd8189, 16'd8229, 16'd8269, 16'd8308, 16'd8348, 16'd8388,
    16'd8427, 16'd8467, 16'd8506, 16'd8546, 16'd8585, 16'd8625, 16'd8664, 16'd8704, 16'd8743, 16'd8783,
    16'd8822, 16'd8862, 16'd8901, 16'd8940, 16'd8980, 16'd9019, 16'd9059, 16'd9098, 16'd9137, 16'd9177,
    16'd9216, 16'd9255, 16'd9295, 16'd9334, 16'd9373, 16'd9412, 16'd9452, 16'd9491, 16'd9530, 16'd9569,
    16'd9609, 16'd9648, 16'd9687, 16'd9726, 16'd9765, 16'd9804, 16'd9844, 16'd9883, 16'd9922, 16'd9961,
    16'd10000, 16'd10039, 16'd10078, 16'd10117, 16'd10156, 16'd10195, 16'd10234, 16'd10273, 16'd10312, 16'd10351,
    16'd10390, 16'd10429, 16'd10468, 16'd10507, 16'd10546, 16'd10585, 16'd10624, 16'd10663, 16'd10702, 16'd10740,
    16'd10779, 16'd10818, 16'd10857, 16'd10896, 16'd10935, 16'd10973, 16'd11012, 16'd11051, 16'd11090, 16'd11128,
    16'd11167, 16'd11206, 16'd11245, 16'd11283, 16'd11322, 16'd11361, 16'd11399, 16'd11438, 16'd11477, 16'd11515,
    16'd11554, 16'd11593, 16'd11631, 16'd11670, 16'd11708, 16'd11747, 16'd11785, 16'd11824, 16'd11862, 16'd11901,
    16'd11940, 16'd11978, 16'd12016, 16'd12055, 16'd12093, 16'd12132, 16'd12170, 16'd12209, 16'd12247, 16'd12286,
    16'd12324, 16'd12362, 16'd12401, 16'd12439, 16'd12477, 16'd12517, 16'd12555, 16'd12593, 16'd12632, 16'd12670,
    16'd12708, 16'd12746, 16'd12785, 16'd12823, 16'd12861, 16'd12899, 16'd12938, 16'd12976, 16'd13014, 16'd13052,
    16'd13090, 16'd13128, 16'd13167, 16'd13205, 16'd13243, 16'd13281, 16'd13319, 16'd13357, 16'd13395, 16'd13433,
    16'd13471, 16'd13509, 16'd13547, 16'd13585, 16'd13623, 16'd13661, 16'd13699, 16'd13737, 16'd13775, 16'd13813,
    16'd13851, 16'd13889, 16'd13927, 16'd13965, 16'd14003, 16'd14039, 16'd14077, 16'd14115, 16'd14153, 16'd14191,
    16'd14229, 16'd14266, 16'd14304, 16'd14342, 16'd14380, 16'd14418, 16'd14456, 16'd14494, 16'd14532, 16'd14569,
    16'd14607, 16'd14645, 16'd14682, 16'd14720, 16'd14758, 16'd14795, 16'd14833, 16'd14871, 16'd14908, 16'd14946,
    16'd14983, 16'd15021, 16'd15058, 16'd15096, 16'd15134, 16'd15171, 16'd15209, 16'd15246, 16'd15284, 16'd15321,
    16'd15358, 16'd15395, 16'd15432, 16'd15471, 16'd15508, 16'd15546, 16'd15583, 16'd15621, 16'd15658, 16'd15696,
    16'd15733, 16'd15771, 16'd15808, 16'd15845, 16'd15883, 16'd15920, 16'd15956, 16'd15994, 16'd16031, 16'd16068,
    16'd16105, 16'd16143, 16'd16180, 16'd16217, 16'd16254, 16'd16291, 16'd16328, 16'd16366, 16'd16403, 16'd16440,
    16'd16477, 16'd16514, 16'd16551, 16'd16588, 16'd16625, 16'd16662, 16'd16700, 16'd16737, 16'd16774, 16'd16811,
    16'd16848, 16'd16885, 16'd16922, 16'd16959, 16'd16996, 16'd17033, 16'd17069, 16'd17106, 16'd17143, 16'd17180,
    16'd17217, 16'd17254, 16'd17291, 16'd17327, 16'd17364, 16'd17401, 16'd17439, 16'd17475, 16'd17512, 16'd17549,
    16'd17586, 16'd17623, 16'd17659, 16'd17696, 16'd17733, 16'd17770, 16'd17806, 16'd17843, 16'd17880, 16'd17916,
    16'd17953, 16'd17990, 16'd18026, 16'd18063, 16'd18099, 16'd18136, 16'd18173, 16'd18209, 16'd18246, 16'd18282,
    16'd18319, 16'd18355, 16'd18392, 16'd18428, 16'd18465, 16'd18501, 16'd18538, 16'd18574, 16'd18611, 16'd18647,
    16'd18684, 16'd18720, 16'd18756, 16'd18793, 16'd18829, 16'd18865, 16'd18902, 16'd18938, 16'd18974, 16'd19011,
    16'd19047, 16'd19083, 16'd19120, 16'd19156, 16'd19192, 16'd19228, 16'd19266, 16'd19302, 16'd19338, 16'd19374,
    16'd19410, 16'd19447, 16'd19483, 16'd19519, 16'd19555, 16'd19590, 16'd19626, 16'd19662, 16'd19698, 16'd19735,
    16'd19771, 16'd19807, 16'd19843, 16'd19879, 16'd19915, 16'd19951, 16'd19987, 16'd20023, 16'd20059, 16'd20095,
    16'd20131, 16'd20167, 16'd20203, 16'd20238, 16'd20274, 16'd20310, 16'd20346, 16'd20382, 16'd20418, 16'd20454,
    16'd20490, 16'd20525, 16'd20561, 16'd20597, 16'd20633, 16'd20670, 16'd20705, 16'd20741, 16'd20777, 16'd20813,
    16'd20848, 16'd20884, 16'd20920, 16'd20955, 16'd20991, 16'd21027, 16'd21062, 16'd21098, 16'd21134, 16'd21169,
    16'd21205, 16'd21240, 16'd21276, 16'd21312, 16'd21347, 16'd21383, 16'd21419, 16'd21455, 16'd21490, 16'd21526,
    16'd21561, 16'd21597, 16'd21632, 16'd21668, 16'd21703, 16'd21739, 16'd21773, 16'd21808, 16'd21844, 16'd21879,
    16'd21915, 16'd21950, 16'd21985, 16'd22021, 16'd22056, 16'd22091, 16'd22127, 16'd22162, 16'd22197, 16'd22232,
    16'd22268, 16'd22303, 16'd22338, 16'd22373, 16'd22409, 16'd22445, 16'd22480, 16'd22515, 16'd22550, 16'd22585,
    16'd22621, 16'd22656, 16'd22691, 16'd22726, 16'd22761, 16'd22796, 16'd22831, 16'd22866, 16'd22901, 16'd22936,
    16'd22972, 16'd23007, 16'd23042, 16'd23077, 16'd23112, 16'd23147, 16'd23181, 16'd23216, 16'd23251, 16'd23286,
    16'd23321, 16'd23356, 16'd23391, 16'd23426, 16'd23460, 16'd23495, 16'd23530, 16'd23565, 16'd23600, 16'd23635,
    16'd23670, 16'd23705, 16'd23740, 16'd23775, 16'd23809, 16'd23844, 16'd23879, 16'd23914, 16'd23948, 16'd23983,
    16'd24018, 16'd24052, 16'd24087, 16'd24122, 16'd24156, 16'd24191, 16'd24225, 16'd24260, 16'd24295, 16'd24329,
    16'd24364, 16'd24398, 16'd24433, 16'd24467, 16'd24502, 16'd24536, 16'd24571, 16'd24605, 16'd24640, 16'd24674,
    16'd24709, 16'd24743, 16'd24778, 16'd24812, 16'd24846, 16'd24881, 16'd24915, 16'd24950, 16'd24984, 16'd25018,
    16'd25053, 16'd25089, 16'd25121, 16'd25155, 16'd25190, 16'd25224, 16'd25259, 16'd25294, 16'd25328, 16'd25362,
    16'd25396, 16'd25430, 16'd25465, 16'd25499, 16'd25533, 16'd25567, 16'd25601, 16'd25635, 16'd25670, 16'd25704,
    16'd25738, 16'd25772, 16'd25806, 16'd25840, 16'd25874, 16'd25908, 16'd25942, 16'd25976, 16'd26010, 16'd26044,
    16'd26078, 16'd26112, 16'd26146, 16'd26180, 16'd26214, 16'd26248, 16'd26283, 16'd26317, 16'd26350, 16'd26384,
    16'd26418, 16'd26452, 16'd26486, 16'd26520, 16'd26554, 16'd26587, 16'd26621, 16'd26655, 16'd26689, 16'd26722,
    16'd26756, 16'd26790, 16'd26824, 16'd26857, 16'd26891, 16'd26925, 16'd26958, 16'd26992, 16'd27026, 16'd27059,
    16'd27093, 16'd27127, 16'd27160, 16'd27194, 16'd27227, 16'd27261, 16'd27295, 16'd27328, 16'd27362, 16'd27395,
    16'd27429, 16'd27462, 16'd27496, 16'd27529, 16'd27563, 16'd27596, 16'd27631, 16'd27664, 16'd27697, 16'd27731,
    16'd27764, 16'd27798, 16'd27831, 16'd27864, 16'd27898, 16'd27931, 16'd27964, 16'd27998, 16'd28031, 16'd28064,
    16'd28098, 16'd28131, 16'd28164, 16'd28197, 16'd28231, 16'd28264, 16'd28297, 16'd28330, 16'd28363, 16'd28397,
    16'd28430, 16'd28463, 16'd28496, 16'd28529, 16'd28562, 16'd28595, 16'd28630, 16'd28663, 16'd28696, 16'd28729,
    16'd28762, 16'd28795, 16'd28828, 16'd28861, 16'd28894, 16'd28927, 16'd28960, 16'd28993, 16'd29026, 16'd29059,
    16'd29092, 16'd29125, 16'd29158, 16'd29190, 16'd29223, 16'd29256, 16'd29290, 16'd29323, 16'd29356, 16'd29389,
    16'd29421, 16'd29454, 16'd29487, 16'd29520, 16'd29553, 16'd29585, 16'd29618, 16'd29651, 16'd29684, 16'd29716,
    16'd29749, 16'd29782, 16'd29814, 16'd29847, 16'd29880, 16'd29912, 16'd29945, 16'd29978, 16'd30010, 16'd30043,
    16'd30075, 16'd30108, 16'd30141, 16'd30173, 16'd30206, 16'd30238, 16'd30271, 16'd30303, 16'd30336, 16'd30368,
    16'd30401, 16'd30433, 16'd30466, 16'd30498, 16'd30530, 16'd30563, 16'd30595, 16'd30628, 16'd30660, 16'd30692,
    16'd30725, 16'd30757, 16'd30789, 16'd30822, 16'd30854, 16'd30886, 16'd30919, 16'd30951, 16'd30983, 16'd31015,
    16'd31048, 16'd31080, 16'd31112, 16'd31145, 16'd31178, 16'd31210, 16'd31243, 16'd31275, 16'd31307, 16'd31339,
    16'd31371, 16'd31404, 16'd31436, 16'd31468, 16'd31500, 16'd31532, 16'd31564, 16'd31596, 16'd31628, 16'd31660,
    16'd31692, 16'd31724, 16'd31756, 16'd31788, 16'd31820, 16'd31852, 16'd31885, 16'd31917, 16'd31949, 16'd31981,
    16'd32012, 16'd32044, 16'd32076, 16'd32108, 16'd32140, 16'd32172, 16'd32203, 16'd32234, 16'd32266, 16'd32298,
    16'd32330, 16'd32361, 16'd32393, 16'd32425, 16'd32457, 16'd32488, 16'd32521, 16'd32553, 16'd32585, 16'd32616,
    16'd32648, 16'd32679, 16'd32711, 16'd32743, 16'd32774, 16'd32806, 16'd32838, 16'd32869, 16'd32901, 16'd32932,
    16'd32964, 16'd32995, 16'd33027, 16'd33058, 16'd33090, 16'd33121, 16'd33153, 16'd33184, 16'd33216, 16'd33247,
    16'd33279, 16'd33310, 16'd33341, 16'd33373, 16'd33404, 16'd33436, 16'd33468, 16'd33499, 16'd33531, 16'd33562,
    16'd33593, 16'd33625, 16'd33656, 16'd33687, 16'd33718, 16'd33750, 16'd33781, 16'd33812, 16'd33843, 16'd33875,
    16'd33906, 16'd33937, 16'd33968, 16'd33999, 16'd34030, 16'd34062, 16'd34094, 16'd34125, 16'd34155, 16'd34187,
    16'd34218, 16'd34249, 16'd34280, 16'd34311, 16'd34342, 16'd34373, 16'd34404, 16'd34435, 16'd34466, 16'd34497,
    16'd34528, 16'd34559, 16'd34590, 16'd34621, 16'd34652, 16'd34683, 16'd34715, 16'd34746, 16'd34776, 16'd34807,
    16'd34838, 16'd34869, 16'd34900, 16'd34931, 16'd34961, 16'd34992, 16'd35023, 16'd35054, 16'd35085, 16'd35115,
    16'd35146, 16'd35177, 16'd35207, 16'd35238, 16'd35269, 16'd35299, 16'd35330, 16'd35361, 16'd35391, 16'd35422,
    16'd35453, 16'd35483, 16'd35514, 16'd35544, 16'd35575, 16'd35606, 16'd35637, 16'd35668, 16'd35698, 16'd35729,
    16'd35759, 16'd35790, 16'd35820, 16'd35851, 16'd35881, 16'd35912, 16'd35942, 16'd35972, 16'd36003, 16'd36033,
    16'd36064, 16'd36094, 16'd36124, 16'd36155, 16'd36185, 16'd36215, 16'd36246, 16'd36276, 16'd36306, 16'd36336,
    16'd36367, 16'd36397, 16'd36427, 16'd36457, 16'd36488, 16'd36518, 16'd36549, 16'd36579, 16'd36609, 16'd36640,
    16'd36670, 16'd36700, 16'd36730, 16'd36760, 16'd36790, 16'd36820, 16'd36850, 16'd36881, 16'd36911, 16'd36941,
    16'd36971, 16'd37001, 16'd37031, 16'd37061, 16'd37091, 16'd37121, 16'd37152, 16'd37182, 16'd37212, 16'd37241,
    16'd37271, 16'd37301, 16'd37331, 16'd37361, 16'd37391, 16'd37421, 16'd37451, 16'd37480, 16'd37510, 16'd37540,
    16'd37570, 16'd37600, 16'd37629, 16'd37659, 16'd37689, 16'd37719, 16'd37749, 16'd37779, 16'd37809, 16'd37839,
    16'd37868, 16'd37898, 16'd37928, 16'd37957, 16'd37987, 16'd38017, 16'd38046, 16'd38076, 16'd38105, 16'd38135,
    16'd38165, 16'd38194, 16'd38224, 16'd38253, 16'd38283, 16'd38312, 16'd38342, 16'd38371, 16'd38401, 16'd38430,
    16'd38460, 16'd38489, 16'd38518, 16'd38548, 16'd38577, 16'd38607, 16'd38637, 16'd38666, 16'd38696, 16'd38725,
    16'd38755, 16'd38784, 16'd38813, 16'd38842, 16'd38872, 16'd38901, 16'd38931, 16'd38961, 16'd38990, 16'd39019,
    16'd39048
  };

  localparam logic [15:0] ROM_FIRST_VAL = ROM_TABLE[0];
  localparam logic [15:0] ROM_LAST_VAL  = ROM_TABLE[LAST_IDX];

endpackage

`default_nettype wire

@@ design/rtdlut_front.sv @@
// ----------------------------------------------------------------------------
// rtdlut_front
// Input stage: holds the sensor mode, scales Pt1000 readings and classifies
// each beat as below, above or inside the table before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdlut_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rtdlut_pkg::RES_W-1:0]  in_resistance_centiohm,
  output logic                               push,
  output rtdlut_pkg::item_t                  push_data,
  input  wire logic                          q_full
);

  logic                         pt1000_r;
  logic                         f_valid_r;
  logic                         f_pt1000_r;
  logic [rtdlut_pkg::RES_W-1:0] f_res_r;
  logic [31:0]                  prod;
  logic [31:0]                  quot;
  logic [rtdlut_pkg::RES_W-1:0] scaled;
  logic                         accept;

  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid_r && !q_full;

  always_comb begin
    prod   = 32'(f_res_r) * 32'(rtdlut_pkg::DIV10_MUL);
    quot   = prod >> rtdlut_pkg::DIV10_SHIFT;
    scaled = f_pt1000_r ? quot[rtdlut_pkg::RES_W-1:0] : f_res_r;
    push_data.scaled = scaled;
    if (scaled <= rtdlut_pkg::ROM_FIRST_VAL) begin
      push_data.cls = rtdlut_pkg::CLS_BELOW;
    end else if (scaled >= rtdlut_pkg::ROM_LAST_VAL) begin
      push_data.cls = rtdlut_pkg::CLS_ABOVE;
    end else begin
      push_data.cls = rtdlut_pkg::CLS_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt1000_r  <= 1'b0;
      f_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pt1000_r <= cfg_wdata;
      end
      if (accept) begin
        f_valid_r <= 1'b1;
      end else if (push) begin
        f_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_res_r    <= in_resistance_centiohm;
      f_pt1000_r <= pt1000_r;
    end
  end

endmodule

`default_nettype wire

@@ design/rtdlut_queue.sv @@
// ----------------------------------------------------------------------------
// rtdlut_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdlut_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rtdlut_pkg::item_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output rtdlut_pkg::item_t      pop_data,
  output logic                   not_empty
);

  rtdlut_pkg::item_t slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ design/rtdlut_back.sv @@
// ----------------------------------------------------------------------------
// rtdlut_back
// Binary search over the resistance ROM, shift-subtract divide for the
// hundredths, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdlut_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_not_empty,
  input  wire rtdlut_pkg::item_t              q_data,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rtdlut_pkg::TEMP_W-1:0]       out_temperature_centideg
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t                             state_r;
  logic                               out_valid_r;
  logic [rtdlut_pkg::TEMP_W-1:0]      out_temp_r;
  logic [rtdlut_pkg::TEMP_W-1:0]      res_r;
  logic [rtdlut_pkg::RES_W-1:0]       s_r;
  logic [rtdlut_pkg::IDX_W-1:0]       lo_r;
  logic [rtdlut_pkg::IDX_W-1:0]       hi_r;
  logic [15:0]                        lo_val_r;
  logic [15:0]                        hi_val_r;
  logic [15:0]                        rom_q_r;
  logic [15:0]                        den_r;
  logic [rtdlut_pkg::NUM_W-1:0]       rem_r;
  logic [rtdlut_pkg::FRAC_W-1:0]      q_r;
  logic [2:0]                         bit_r;
  logic [rtdlut_pkg::IDX_W:0]         idx_sum;
  logic [rtdlut_pkg::IDX_W-1:0]       mid;
  logic [rtdlut_pkg::NUM_W:0]         trial;
  logic [rtdlut_pkg::NUM_W-1:0]       den_sh;
  logic [rtdlut_pkg::NUM_W-1:0]       num;
  logic [rtdlut_pkg::TEMP_W-1:0]      whole;
  logic [rtdlut_pkg::FRAC_W-1:0]      frac;
  logic                               slot_free;

  assign out_valid                = out_valid_r;
  assign out_temperature_centideg = out_temp_r;
  assign slot_free                = !out_valid_r || !out_stall;
  assign pop                      = (state_r == ST_IDLE) && q_not_empty;

  always_comb begin
    idx_sum = {1'b0, lo_r} + {1'b0, hi_r};
    mid     = idx_sum[rtdlut_pkg::IDX_W:1];
    den_sh  = {7'b0, den_r} << bit_r;
    trial   = {1'b0, rem_r} - {1'b0, den_sh};
    num     = rtdlut_pkg::NUM_W'((s_r - lo_val_r) * rtdlut_pkg::CENTI);
    whole   = rtdlut_pkg::TEMP_W'({7'b0, lo_r} * 18'(rtdlut_pkg::CENTI));
    // equal neighbours would leave no fraction
    frac    = (den_r == 16'd0) ? '0 : q_r;
  end

  // ROM read port, address from the current search window
  always_ff @(posedge clk) begin
    rom_q_r <= rtdlut_pkg::ROM_TABLE[mid];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            s_r      <= q_data.scaled;
            lo_r     <= '0;
            hi_r     <= rtdlut_pkg::IDX_W'(rtdlut_pkg::LAST_IDX);
            lo_val_r <= rtdlut_pkg::ROM_FIRST_VAL;
            hi_val_r <= rtdlut_pkg::ROM_LAST_VAL;
            unique case (q_data.cls)
              rtdlut_pkg::CLS_BELOW: begin
                res_r   <= rtdlut_pkg::TEMP_LOW_C;
                state_r <= ST_DONE;
              end
              rtdlut_pkg::CLS_ABOVE: begin
                res_r   <= rtdlut_pkg::TEMP_HIGH_C;
                state_r <= ST_DONE;
              end
              default: begin
                state_r <= ST_READ;
              end
            endcase
          end
        end
        ST_READ: begin
          if (hi_r - lo_r > rtdlut_pkg::IDX_W'(1)) begin
            state_r <= ST_CMP;
          end else begin
            den_r   <= hi_val_r - lo_val_r;
            rem_r   <= num;
            q_r     <= '0;
            bit_r   <= 3'(rtdlut_pkg::FRAC_W - 1);
            state_r <= ST_DIV;
          end
        end
        ST_CMP: begin
          if (rom_q_r <= s_r) begin
            lo_r     <= mid;
            lo_val_r <= rom_q_r;
          end else begin
            hi_r     <= mid;
            hi_val_r <= rom_q_r;
          end
          state_r <= ST_READ;
        end
        ST_DIV: begin
          if (!trial[rtdlut_pkg::NUM_W]) begin
            rem_r        <= trial[rtdlut_pkg::NUM_W-1:0];
            q_r[bit_r]   <= 1'b1;
          end
          if (bit_r == 3'd0) begin
            state_r <= ST_FIN;
          end else begin
            bit_r <= bit_r - 3'd1;
          end
        end
        ST_FIN: begin
          res_r   <= whole + {11'b0, frac} + rtdlut_pkg::TEMP_LOW_C;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            out_temp_r  <= res_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // search window always brackets the scaled value
  a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (lo_val_r <= s_r && s_r < hi_val_r))
    else $error("search window lost the value");

  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (hi_r > lo_r + rtdlut_pkg::IDX_W'(1)))
    else $error("probe issued on a closed window");

  // partial remainder stays below the divisor at the next bit weight
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && den_r != 16'd0) |->
      ({1'b0, rem_r} < ({8'b0, den_r} << (4'(bit_r) + 4'd1))))
    else $error("divide remainder out of range");

  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r != ST_IDLE))
    else $error("popped item not taken up");

endmodule

`default_nettype wire

@@ design/rtd_resistance_to_temperature_lut.sv @@
// path: a beat that clamps at either table end skips the search and divide; one inside
// the table passes the front register and queue, up to 11 ROM probes, a window
// check, 7 divide steps, result and output register
// flow: the back takes a new beat only once the last is out, set by the search loop
// on the single registered ROM read port; clamped beats skip the loop but not out_stall
// reset: synchronous active-low rst_n clears the queue, the sequencer and the mode (Pt100)
// ----------------------------------------------------------------------------
// rtd_resistance_to_temperature_lut
// Pt100/Pt1000 resistance to temperature by ROM search and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module rtd_resistance_to_temperature_lut (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rtdlut_pkg::RES_W-1:0]  in_resistance_centiohm,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rtdlut_pkg::TEMP_W-1:0]      out_temperature_centideg
);

  logic              push;
  rtdlut_pkg::item_t push_data;
  logic              q_full;
  logic              pop;
  rtdlut_pkg::item_t pop_data;
  logic              q_not_empty;

  rtdlut_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_resistance_centiohm (in_resistance_centiohm),
    .push                   (push),
    .push_data              (push_data),
    .q_full                 (q_full)
  );

  rtdlut_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty)
  );

  rtdlut_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .q_not_empty              (q_not_empty),
    .q_data                   (pop_data),
    .pop                      (pop),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_temperature_centideg (out_temperature_centideg)
  );

endmodule

`default_nettype wire
